### rtl/phse_pkg.sv
// Shared types and constants for the periodic Hermite spline evaluator.
// No dependencies; imported by every module of the block but phse_ram.
`default_nettype none

package phse_pkg;

	localparam int SEGMENTS_DEF   = 20;
	localparam int COEF_WIDTH_DEF = 32;

	// 1/(2*pi) in Q32
	localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;

	// s1 input regs, s2 segment split, s3 table read, s4..s7 basis weights,
	// s8..s11 multiply-accumulate, s12 saturation / output register
	localparam int NUM_STAGES = 12;
	typedef logic [NUM_STAGES-1:0] stage_vec_t;

	// basis weight width, signed
	localparam int W_W = 48;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ORD_VALUE = 2'd0,
		ORD_D1    = 2'd1,
		ORD_D2    = 2'd2,
		ORD_NONE  = 2'd3
	} order_t;

	typedef struct packed {
		logic               op;
		logic [5:0]         coef_index;
		logic signed [31:0] coef_value;
		logic [15:0]        angle;
		logic [1:0]         deriv_order;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] spline_value;
		logic               saturated;
		logic               unsupported;
	} out_item_t;

endpackage

`default_nettype wire

### rtl/phse_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// Self-contained; used for the knot value and knot slope banks.
`default_nettype none

module phse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 20
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]              rdata_a,
	output logic [WIDTH-1:0]              rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

### rtl/phse_coef_store.sv
// Knot coefficient table: value bank and slope bank, each a phse_ram, plus
// per-entry valid bits so that unwritten entries read as zero after reset.
`default_nettype none

module phse_coef_store
	import phse_pkg::*;
#(
	parameter int SEGMENTS   = SEGMENTS_DEF,
	parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [$clog2(SEGMENTS)-1:0] wr_knot,
	input  wire logic                        wr_slope,
	input  wire logic [((COEF_WIDTH < 32) ? COEF_WIDTH : 32)-1:0] wr_data,
	input  wire logic                        rd_en,
	input  wire logic [$clog2(SEGMENTS)-1:0] rd_seg,
	input  wire logic [$clog2(SEGMENTS)-1:0] rd_nxt,
	output logic signed [31:0]               coef [4]
);

	localparam int CW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;

	logic [CW-1:0]       val_a, val_b, slp_a, slp_b;
	logic [SEGMENTS-1:0] val_vld_q, slp_vld_q;
	logic [3:0]          hit_s3;

	phse_ram #(.WIDTH(CW), .DEPTH(SEGMENTS)) u_val_bank (
		.clk     (clk),
		.we      (wr_en && !wr_slope),
		.waddr   (wr_knot),
		.wdata   (wr_data),
		.re      (rd_en),
		.raddr_a (rd_seg),
		.raddr_b (rd_nxt),
		.rdata_a (val_a),
		.rdata_b (val_b)
	);

	phse_ram #(.WIDTH(CW), .DEPTH(SEGMENTS)) u_slp_bank (
		.clk     (clk),
		.we      (wr_en && wr_slope),
		.waddr   (wr_knot),
		.wdata   (wr_data),
		.re      (rd_en),
		.raddr_a (rd_seg),
		.raddr_b (rd_nxt),
		.rdata_a (slp_a),
		.rdata_b (slp_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_vld_q <= '0;
			slp_vld_q <= '0;
			hit_s3    <= '0;
		end else begin
			if (wr_en) begin
				if (wr_slope) begin
					slp_vld_q[wr_knot] <= 1'b1;
				end else begin
					val_vld_q[wr_knot] <= 1'b1;
				end
			end
			if (rd_en) begin
				hit_s3 <= {slp_vld_q[rd_nxt], val_vld_q[rd_nxt],
				           slp_vld_q[rd_seg], val_vld_q[rd_seg]};
			end
		end
	end

	// slot order: value(i), slope(i), value(i+1), slope(i+1)
	always_comb begin
		coef[0] = hit_s3[0] ? 32'($signed(val_a)) : '0;
		coef[1] = hit_s3[1] ? 32'($signed(slp_a)) : '0;
		coef[2] = hit_s3[2] ? 32'($signed(val_b)) : '0;
		coef[3] = hit_s3[3] ? 32'($signed(slp_b)) : '0;
	end

`ifndef NO_ASSERTIONS
	a_val_marked: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !wr_slope |=> val_vld_q[$past(wr_knot)])
		else $error("value entry not marked valid after write");
`endif

endmodule

`default_nettype wire

### rtl/phse_basis.sv
// Basis weight pipeline, stages s3..s7: powers of s, Hermite basis (or its
// derivative) in Q48 rounded to Q30, then scaling by SEGMENTS/(2*pi) per order.
`default_nettype none

module phse_basis
	import phse_pkg::*;
#(
	parameter int SEGMENTS = SEGMENTS_DEF
) (
	input  wire logic              clk,
	input  wire stage_vec_t        stage_en,
	input  wire logic [15:0]       u_s2,
	input  wire order_t            order_s2,
	output logic signed [W_W-1:0]  w_s7 [4],
	output order_t                 ord_s7
);

	localparam logic [63:0] K24 = (64'(SEGMENTS) * INV_TWO_PI_Q32 + 64'd128) >> 8;
	localparam logic [63:0] K2  = (K24 * K24 + 64'h8000_0000) >> 32;
	localparam int          KM_W   = 32;
	localparam int          P30_W  = 34;
	localparam int          PROD_W = P30_W + KM_W;

	localparam logic signed [KM_W-1:0] KM_D1  = KM_W'(K24);
	localparam logic signed [KM_W-1:0] KM_D2  = KM_W'(K2);
	localparam logic signed [KM_W-1:0] KM_ONE = KM_W'(65536);

	localparam logic signed [53:0] ONE_Q48 = 54'sh1_0000_0000_0000;
	localparam logic signed [53:0] RND18   = 54'sd131072;
	localparam logic signed [PROD_W-1:0] RND24 = PROD_W'(8388608);
	localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(32768);

	logic [15:0] u_s3, u_s4;
	logic [31:0] u2_s3, u2_s4;
	logic [47:0] u3_s4;
	order_t      ord_s3, ord_s4, ord_s5, ord_s6;

	logic signed [P30_W-1:0]  p30_s5 [4];
	logic signed [PROD_W-1:0] prod_s6 [4];

	logic signed [53:0]       a1, a2, a3;
	logic signed [53:0]       pc [4];
	logic signed [53:0]       pr [4];
	logic signed [KM_W-1:0]   kmul;
	logic signed [PROD_W-1:0] wsum [4];

	// s3, s4: powers of u
	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			u_s3   <= u_s2;
			u2_s3  <= 32'(u_s2) * 32'(u_s2);
			ord_s3 <= order_s2;
		end
		if (stage_en[3]) begin
			u_s4   <= u_s3;
			u2_s4  <= u2_s3;
			u3_s4  <= 48'(u2_s3) * 48'(u_s3);
			ord_s4 <= ord_s3;
		end
	end

	// s5: polynomial in Q48, rounded half up to Q30
	always_comb begin
		a1 = $signed({6'd0, u_s4, 32'd0});
		a2 = $signed({6'd0, u2_s4, 16'd0});
		a3 = $signed({6'd0, u3_s4});
		case (ord_s4)
			ORD_VALUE: begin
				pc[0] = ONE_Q48 - 54'sd3 * a2 + 54'sd2 * a3;
				pc[1] = a1 - 54'sd2 * a2 + a3;
				pc[2] = 54'sd3 * a2 - 54'sd2 * a3;
				pc[3] = a3 - a2;
			end
			ORD_D1: begin
				pc[0] = 54'sd6 * (a2 - a1);
				pc[1] = ONE_Q48 - 54'sd4 * a1 + 54'sd3 * a2;
				pc[2] = 54'sd6 * (a1 - a2);
				pc[3] = 54'sd3 * a2 - 54'sd2 * a1;
			end
			ORD_D2: begin
				pc[0] = 54'sd12 * a1 - 54'sd6 * ONE_Q48;
				pc[1] = 54'sd6 * a1 - 54'sd4 * ONE_Q48;
				pc[2] = 54'sd6 * ONE_Q48 - 54'sd12 * a1;
				pc[3] = 54'sd6 * a1 - 54'sd2 * ONE_Q48;
			end
			default: begin
				for (int t = 0; t < 4; t++) begin
					pc[t] = '0;
				end
			end
		endcase
		for (int t = 0; t < 4; t++) begin
			pr[t] = (pc[t] + RND18) >>> 18;
		end
	end

	// order 0 goes through the multiplier as x * 2^16 >> 16, which is exact
	always_comb begin
		case (ord_s5)
			ORD_D1:  kmul = KM_D1;
			ORD_D2:  kmul = KM_D2;
			default: kmul = KM_ONE;
		endcase
		for (int t = 0; t < 4; t++) begin
			wsum[t] = prod_s6[t] + ((ord_s6 == ORD_D1) ? RND24 : RND16);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			for (int t = 0; t < 4; t++) begin
				p30_s5[t] <= P30_W'(pr[t]);
			end
			ord_s5 <= ord_s4;
		end
		if (stage_en[5]) begin
			for (int t = 0; t < 4; t++) begin
				prod_s6[t] <= p30_s5[t] * kmul;
			end
			ord_s6 <= ord_s5;
		end
		if (stage_en[6]) begin
			for (int t = 0; t < 4; t++) begin
				w_s7[t] <= (ord_s6 == ORD_D1) ? W_W'(wsum[t] >>> 24) : W_W'(wsum[t] >>> 16);
			end
			ord_s7 <= ord_s6;
		end
	end

endmodule

`default_nettype wire

### rtl/phse_mac.sv
// Multiply-accumulate pipeline, stages s4..s12: coefficient delay, split
// products, adder tree, Q46 -> Q16 rounding and 32-bit saturation.
`default_nettype none

module phse_mac
	import phse_pkg::*;
(
	input  wire logic                   clk,
	input  wire stage_vec_t             stage_en,
	input  wire logic signed [31:0]     coef_s3 [4],
	input  wire logic signed [W_W-1:0]  w_s7 [4],
	input  wire logic                   unsup_s7,
	output logic signed [31:0]          value_s12,
	output logic                        sat_s12,
	output logic                        unsup_s12
);

	localparam int HP_W = 32 + W_W - 24;   // coef x upper weight part
	localparam int LP_W = 32 + 25;         // coef x unsigned low 24 bits
	localparam int T_W  = HP_W + 2 + 24 + 2;
	localparam int R_W  = T_W - 30;

	localparam logic signed [T_W-1:0] RND29 = T_W'(536870912);
	localparam logic signed [R_W-1:0] R_MAX = R_W'(64'sd2147483647);
	localparam logic signed [R_W-1:0] R_MIN = R_W'(-64'sd2147483648);

	logic signed [31:0]     c_s4 [4];
	logic signed [31:0]     c_s5 [4];
	logic signed [31:0]     c_s6 [4];
	logic signed [31:0]     c_s7 [4];
	logic signed [HP_W-1:0] hi_s8 [4];
	logic signed [LP_W-1:0] lo_s8 [4];
	logic signed [HP_W:0]   hsum_s9 [2];
	logic signed [LP_W:0]   lsum_s9 [2];
	logic signed [HP_W+1:0] h_s10;
	logic signed [LP_W+1:0] l_s10;
	logic signed [R_W-1:0]  r_s11;
	logic                   unsup_s8, unsup_s9, unsup_s10, unsup_s11;
	logic signed [T_W-1:0]  total;

	// exact sum of coef*weight in Q46, then round half up to Q16
	assign total = (T_W'(h_s10) <<< 24) + T_W'(l_s10) + RND29;

	always_ff @(posedge clk) begin
		if (stage_en[3]) c_s4 <= coef_s3;
		if (stage_en[4]) c_s5 <= c_s4;
		if (stage_en[5]) c_s6 <= c_s5;
		if (stage_en[6]) c_s7 <= c_s6;
		if (stage_en[7]) begin
			for (int t = 0; t < 4; t++) begin
				hi_s8[t] <= c_s7[t] * $signed(w_s7[t][W_W-1:24]);
				lo_s8[t] <= c_s7[t] * $signed({1'b0, w_s7[t][23:0]});
			end
			unsup_s8 <= unsup_s7;
		end
		if (stage_en[8]) begin
			hsum_s9[0] <= (HP_W+1)'(hi_s8[0]) + (HP_W+1)'(hi_s8[1]);
			hsum_s9[1] <= (HP_W+1)'(hi_s8[2]) + (HP_W+1)'(hi_s8[3]);
			lsum_s9[0] <= (LP_W+1)'(lo_s8[0]) + (LP_W+1)'(lo_s8[1]);
			lsum_s9[1] <= (LP_W+1)'(lo_s8[2]) + (LP_W+1)'(lo_s8[3]);
			unsup_s9   <= unsup_s8;
		end
		if (stage_en[9]) begin
			h_s10     <= (HP_W+2)'(hsum_s9[0]) + (HP_W+2)'(hsum_s9[1]);
			l_s10     <= (LP_W+2)'(lsum_s9[0]) + (LP_W+2)'(lsum_s9[1]);
			unsup_s10 <= unsup_s9;
		end
		if (stage_en[10]) begin
			r_s11     <= R_W'(total >>> 30);
			unsup_s11 <= unsup_s10;
		end
		if (stage_en[11]) begin
			if (r_s11 > R_MAX) begin
				value_s12 <= 32'sh7fff_ffff;
				sat_s12   <= 1'b1;
			end else if (r_s11 < R_MIN) begin
				value_s12 <= 32'sh8000_0000;
				sat_s12   <= 1'b1;
			end else begin
				value_s12 <= 32'(r_s11);
				sat_s12   <= 1'b0;
			end
			unsup_s12 <= unsup_s11;
		end
	end

endmodule

`default_nettype wire

### rtl/periodic_hermite_spline_eval_core.sv
// Periodic cubic Hermite spline evaluator, top level.
// Uses phse_pkg, phse_coef_store (with phse_ram), phse_basis and phse_mac.
//
// Usage:
//  - item channel (item_valid/item_ready/item): op OP_WRITE stores one knot
//    coefficient (even index = value, odd = slope; index >= 2*SEGMENTS is
//    dropped) and produces no result. op OP_EVAL evaluates the spline, or its
//    first or second derivative, at angle (fraction of a turn).
//  - result channel (result_valid/result_ready/result): one transfer per
//    evaluate item, in item order. deriv_order 3 returns zero with unsupported.
//  - Result path: an evaluate item moves through stages s1 to s12 in order and
//    its result is offered from the s12 output register.
//  - Throughput: one item per cycle unless stalled, set by a 12-stage pipeline
//    where each stage holds one item; a write takes effect for every later item.
//  - The table sits in two dual-read RAMs (value and slope banks) read at
//    knots i and i+1 in the same cycle.
//  - Reset: the pipeline empties and all coefficients read as zero at once;
//    item_ready is high from the first cycle after reset.
//  - Stall: when result_ready is low the pipeline keeps taking items until
//    every stage holds one; no item is dropped or repeated.
`default_nettype none

module periodic_hermite_spline_eval_core
	import phse_pkg::*;
#(
	parameter int SEGMENTS   = SEGMENTS_DEF,
	parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire in_item_t  item,
	output logic           result_valid,
	input  wire logic      result_ready,
	output out_item_t      result
);

	localparam int KW = $clog2(SEGMENTS);
	localparam int CW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
	localparam int PW = 16 + KW;

	stage_vec_t stage_vld_q;
	stage_vec_t vld_in;
	stage_vec_t en;

	in_item_t          item_s1;
	op_t               op_s2;
	order_t            order_s2;
	logic [KW-1:0]     seg_s2, nxt_s2, knot_s2;
	logic [15:0]       u_s2;
	logic              slope_s2, wr_ok_s2;
	logic [CW-1:0]     wdata_s2;

	logic [PW-1:0]     pos;
	logic [KW-1:0]     seg_c;

	logic signed [31:0]    coef_s3 [4];
	logic signed [W_W-1:0] w_s7 [4];
	order_t                ord_s7;
	logic signed [31:0]    value_s12;
	logic                  sat_s12, unsup_s12;

	// a stage may load when the result is taken or some stage at or after it is empty
	always_comb begin
		for (int i = 0; i < NUM_STAGES; i++) begin
			en[i] = result_ready || ((~stage_vld_q & (stage_vec_t'('1) << i)) != '0);
		end
		vld_in    = {stage_vld_q[NUM_STAGES-2:0], item_valid};
		// write items leave the pipeline once they reach the table
		vld_in[2] = stage_vld_q[1] && (op_s2 == OP_EVAL);
	end

	assign item_ready   = en[0];
	assign result_valid = stage_vld_q[NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				if (en[i]) begin
					stage_vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	// s2: segment index and local position from angle*SEGMENTS
	always_comb begin
		pos   = PW'(25'(item_s1.angle) * 25'(SEGMENTS));
		seg_c = pos[PW-1:16];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			item_s1 <= item;
		end
		if (en[1]) begin
			op_s2    <= op_t'(item_s1.op);
			order_s2 <= order_t'(item_s1.deriv_order);
			seg_s2   <= seg_c;
			nxt_s2   <= (seg_c == KW'(SEGMENTS - 1)) ? '0 : seg_c + 1'b1;
			u_s2     <= pos[15:0];
			knot_s2  <= KW'(item_s1.coef_index[5:1]);
			slope_s2 <= item_s1.coef_index[0];
			wr_ok_s2 <= 10'(item_s1.coef_index) < 10'(2 * SEGMENTS);
			wdata_s2 <= item_s1.coef_value[CW-1:0];
		end
	end

	phse_coef_store #(.SEGMENTS(SEGMENTS), .COEF_WIDTH(COEF_WIDTH)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (en[2] && stage_vld_q[1] && (op_s2 == OP_WRITE) && wr_ok_s2),
		.wr_knot  (knot_s2),
		.wr_slope (slope_s2),
		.wr_data  (wdata_s2),
		.rd_en    (en[2]),
		.rd_seg   (seg_s2),
		.rd_nxt   (nxt_s2),
		.coef     (coef_s3)
	);

	phse_basis #(.SEGMENTS(SEGMENTS)) u_basis (
		.clk      (clk),
		.stage_en (en),
		.u_s2     (u_s2),
		.order_s2 (order_s2),
		.w_s7     (w_s7),
		.ord_s7   (ord_s7)
	);

	phse_mac u_mac (
		.clk       (clk),
		.stage_en  (en),
		.coef_s3   (coef_s3),
		.w_s7      (w_s7),
		.unsup_s7  (ord_s7 == ORD_NONE),
		.value_s12 (value_s12),
		.sat_s12   (sat_s12),
		.unsup_s12 (unsup_s12)
	);

	// order 3 yields zero weights, so value and saturation flag come out zero on their own
	assign result.spline_value = value_s12;
	assign result.saturated    = sat_s12;
	assign result.unsupported  = unsup_s12;

`ifndef NO_ASSERTIONS
	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.unsupported |->
			(result.spline_value == 32'sd0) && !result.saturated)
		else $error("unsupported result is not zero");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |->
			(result.spline_value == 32'sh7fff_ffff) ||
			(result.spline_value == 32'sh8000_0000))
		else $error("saturated result not at a range limit");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_vld_q == '0) |-> item_ready)
		else $error("empty pipeline refuses an item");
`endif

endmodule

`default_nettype wire
